### sv/sab_pkg.sv
// ============================================================================
// sab_pkg
// Shared types, codes and constants of the session ack binder.
// ============================================================================
package sab_pkg;

   // Default expected length of an ack packet in bytes
   localparam int unsigned ACK_LENGTH_DEFAULT = 51;

   // Recognised ack opcode, minimum length for opcode inspection, version
   localparam logic [15:0] ACK_OPCODE      = 16'h1007;
   localparam logic [15:0] MIN_PKT_LENGTH  = 16'd6;
   localparam logic [7:0]  ACK_VERSION     = 8'd1;

   // Stream widths
   localparam int unsigned REQ_TDATA_W = 400;
   localparam int unsigned RSP_TDATA_W = 48;
   localparam int unsigned CSR_ADDR_W  = 2;
   localparam int unsigned CSR_DATA_W  = 64;

   // Register indexes of the configuration port
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_RUN_ID_LOW  = 2'd0,
      CSR_RUN_ID_HIGH = 2'd1,
      CSR_RUN_VALID   = 2'd2
   } csr_index_type;

   // Event kinds on the request channel
   typedef enum logic [1:0] {
      ACT_BEGIN  = 2'd0,
      ACT_PACKET = 2'd1,
      ACT_READY  = 2'd2
   } action_type;

   // Connection states
   typedef enum logic [1:0] {
      LINK_UNBOUND = 2'd0,
      LINK_PENDING = 2'd1,
      LINK_BOUND   = 2'd2,
      LINK_UNAVAIL = 2'd3
   } link_state_type;

   // Result status codes
   typedef enum logic [3:0] {
      STATUS_OK           = 4'd0,
      STATUS_LENGTH       = 4'd1,
      STATUS_VERSION      = 4'd2,
      STATUS_RUN_UNAVAIL  = 4'd3,
      STATUS_RUN_MISMATCH = 4'd4,
      STATUS_ZERO_ATTEMPT = 4'd5,
      STATUS_ZERO_BOOT    = 4'd6,
      STATUS_NEG_SESSION  = 4'd7,
      STATUS_STALE        = 4'd8,
      STATUS_ALREADY      = 4'd9,
      STATUS_NOT_PENDING  = 4'd10,
      STATUS_NOT_CONSUMED = 4'd11
   } status_type;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic [63:0] run_id_low;
      logic [63:0] run_id_high;
      logic        run_valid;
   } cfg_type;

   // One request beat, unpacked
   typedef struct packed {
      action_type  action;
      logic        ready_flag;
      logic [15:0] packet_length;
      logic [15:0] ack_opcode;
      logic [7:0]  ack_version;
      logic [63:0] ack_run_low;
      logic [63:0] ack_run_high;
      logic [31:0] ack_attempt;
      logic [63:0] ack_boot_low;
      logic [63:0] ack_boot_high;
      logic [63:0] ack_session;
   } item_type;

   // Connection state kept between beats
   typedef struct packed {
      link_state_type link_state;
      logic [31:0]    attempt_count;
      logic           consumer_ready;
      logic [63:0]    bound_boot_low;
      logic [63:0]    bound_boot_high;
      logic [62:0]    bound_session;
   } link_type;

   // One response beat, unpacked
   typedef struct packed {
      status_type     status;
      logic           consumed;
      logic           newly_bound;
      logic           begin_available;
      logic [31:0]    attempt_out;
      link_state_type connection_state;
   } result_type;

endpackage

### sv/sab_csr.sv
// ============================================================================
// sab_csr
// Configuration registers: run id and its valid flag, write-only.
// ============================================================================
module sab_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [sab_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [sab_pkg::CSR_DATA_W-1:0]      csr_wdata,
   output sab_pkg::cfg_type                    cfg
);
   import sab_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // decode the write; indexes beyond the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_RUN_ID_LOW:  cfg_in.run_id_low  = csr_wdata;
            CSR_RUN_ID_HIGH: cfg_in.run_id_high = csr_wdata;
            CSR_RUN_VALID:   cfg_in.run_valid   = csr_wdata[0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### sv/sab_eval.sv
// ============================================================================
// sab_eval
// Single-pass evaluation of one event against the connection state.
// ============================================================================
module sab_eval #(
   parameter int unsigned ACK_LENGTH = sab_pkg::ACK_LENGTH_DEFAULT
) (
   input  sab_pkg::cfg_type    cfg,
   input  sab_pkg::item_type   item,
   input  sab_pkg::link_type   cur,
   output sab_pkg::link_type   nxt,
   output sab_pkg::result_type res
);
   import sab_pkg::*;

   localparam logic [15:0] AckLen = 16'(ACK_LENGTH);

   status_type pkt_status;
   logic       pkt_bind;
   logic       begin_ok;

   // packet checks, first failing check wins
   always_comb begin
      pkt_bind = 1'b0;
      priority if (item.packet_length < MIN_PKT_LENGTH || item.ack_opcode != ACK_OPCODE)
         pkt_status = STATUS_NOT_CONSUMED;
      else if (item.packet_length != AckLen)
         pkt_status = STATUS_LENGTH;
      else if (item.ack_version != ACK_VERSION)
         pkt_status = STATUS_VERSION;
      else if (!cfg.run_valid)
         pkt_status = STATUS_RUN_UNAVAIL;
      else if (item.ack_run_low != cfg.run_id_low || item.ack_run_high != cfg.run_id_high)
         pkt_status = STATUS_RUN_MISMATCH;
      else if (item.ack_attempt == '0)
         pkt_status = STATUS_ZERO_ATTEMPT;
      else if ((item.ack_boot_low | item.ack_boot_high) == '0)
         pkt_status = STATUS_ZERO_BOOT;
      else if (item.ack_session[63])
         pkt_status = STATUS_NEG_SESSION;
      else if (item.ack_attempt != cur.attempt_count)
         pkt_status = STATUS_STALE;
      else if (cur.link_state == LINK_BOUND) begin
         // same pair is acknowledged again with ok status, any other pair is refused
         if (item.ack_boot_low != cur.bound_boot_low
             || item.ack_boot_high != cur.bound_boot_high
             || item.ack_session[62:0] != cur.bound_session)
            pkt_status = STATUS_ALREADY;
         else
            pkt_status = STATUS_OK;
      end
      else if (cur.link_state != LINK_PENDING)
         pkt_status = STATUS_NOT_PENDING;
      else begin
         pkt_status = STATUS_OK;
         pkt_bind   = 1'b1;
      end
   end

   assign begin_ok = cfg.run_valid && cur.consumer_ready && (cur.attempt_count != '1);

   // state update and result fields
   always_comb begin
      nxt                 = cur;
      res.status          = STATUS_OK;
      res.consumed        = 1'b0;
      res.newly_bound     = 1'b0;
      res.begin_available = 1'b0;
      unique case (item.action)
         ACT_BEGIN: begin
            if (begin_ok) begin
               nxt.attempt_count   = cur.attempt_count + 32'd1;
               nxt.link_state      = LINK_PENDING;
               res.begin_available = 1'b1;
            end else begin
               nxt.link_state = LINK_UNAVAIL;
               res.status     = STATUS_RUN_UNAVAIL;
            end
         end
         ACT_PACKET: begin
            res.status   = pkt_status;
            res.consumed = (pkt_status != STATUS_NOT_CONSUMED);
            if (pkt_bind) begin
               nxt.bound_boot_low  = item.ack_boot_low;
               nxt.bound_boot_high = item.ack_boot_high;
               nxt.bound_session   = item.ack_session[62:0];
               nxt.link_state      = LINK_BOUND;
               res.newly_bound     = 1'b1;
            end
         end
         ACT_READY: begin
            nxt.consumer_ready = item.ready_flag;
            if (!item.ready_flag) nxt.link_state = LINK_UNAVAIL;
         end
         default: begin
            nxt = cur;
         end
      endcase
      res.attempt_out      = nxt.attempt_count;
      res.connection_state = nxt.link_state;
   end

endmodule

### sv/session_ack_binder_unit.sv
// ============================================================================
// session_ack_binder_unit
// Binds a connection to a configured run id from begin, ack and readiness
// events; one response beat per request beat.
// ============================================================================
// Usage:
//   req_* : request beats. req_tuser carries the event kind (begin, packet,
//           set readiness); req_tdata carries readiness flag and ack fields.
//   rsp_* : one response beat per request beat, in order: status, flags,
//           attempt count and connection state after the event.
//   csr_* : write-only run id and run-valid registers; write while idle.
// Pipeline: a request beat passes the input register, then evaluation into
//   the response register.
// Throughput: one beat per cycle while rsp_tready is high; the connection
//   state is read and updated in one evaluation pass: no gap between beats.
// Reset: connection state unbound, attempt count zero, consumer not ready,
//   bound pair zero, run id and run-valid zero; both stages empty.
// Stall: while rsp_tready is low the response holds, one more request sits
//   in the input register, then req_tready drops until the response is taken.
// ============================================================================
module session_ack_binder_unit #(
   parameter int unsigned ACK_LENGTH = sab_pkg::ACK_LENGTH_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // request: tuser = action[1:0]
   // tdata = ready_flag, packet_length, ack_opcode, ack_version, ack_run_low,
   //         ack_run_high, ack_attempt, ack_boot_low, ack_boot_high,
   //         ack_session, zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sab_pkg::REQ_TDATA_W-1:0]    req_tdata,
   input  logic [1:0]                         req_tuser,
   // response: tdata = status, consumed, newly_bound, begin_available,
   //           attempt_out, connection_state, zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [sab_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   // configuration
   input  logic                               csr_we,
   input  logic [sab_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [sab_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import sab_pkg::*;

   cfg_type    cfg;
   item_type   req_item;
   item_type   item_ff;
   logic       item_valid_ff;
   logic       item_valid_in;
   link_type   link_ff;
   link_type   link_nxt;
   result_type eval_res;
   result_type rsp_ff;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       fire;
   logic       req_take;

   sab_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // unpack request beat
   always_comb begin
      req_item.action        = action_type'(req_tuser);
      req_item.ready_flag    = req_tdata[0];
      req_item.packet_length = req_tdata[16:1];
      req_item.ack_opcode    = req_tdata[32:17];
      req_item.ack_version   = req_tdata[40:33];
      req_item.ack_run_low   = req_tdata[104:41];
      req_item.ack_run_high  = req_tdata[168:105];
      req_item.ack_attempt   = req_tdata[200:169];
      req_item.ack_boot_low  = req_tdata[264:201];
      req_item.ack_boot_high = req_tdata[328:265];
      req_item.ack_session   = req_tdata[392:329];
   end

   // handshake: evaluate when the response slot is free or draining
   assign fire          = item_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready    = !item_valid_ff || fire;
   assign req_take      = req_tvalid && req_tready;
   assign item_valid_in = req_take || (item_valid_ff && !fire);
   assign rsp_valid_in  = fire || (rsp_valid_ff && !rsp_tready);

   sab_eval #(
      .ACK_LENGTH (ACK_LENGTH)
   ) u_eval (
      .cfg  (cfg),
      .item (item_ff),
      .cur  (link_ff),
      .nxt  (link_nxt),
      .res  (eval_res)
   );

   // control and connection state
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         link_ff       <= '0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (fire) link_ff <= link_nxt;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) item_ff <= req_item;
      if (fire)     rsp_ff  <= eval_res;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_ff.connection_state, rsp_ff.attempt_out,
                        rsp_ff.begin_available, rsp_ff.newly_bound,
                        rsp_ff.consumed, rsp_ff.status};

   // a new binding always reports bound with ok status
   a_newly_bound : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.newly_bound |->
         rsp_ff.connection_state == LINK_BOUND && rsp_ff.status == STATUS_OK)
      else $error("newly bound result without bound state");

   // a successful begin leaves the link pending with a nonzero attempt
   a_begin_ok : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.begin_available |->
         rsp_ff.connection_state == LINK_PENDING && rsp_ff.attempt_out != '0)
      else $error("begin available without pending state");

   // attempt count moves only on an evaluated begin event
   a_attempt_hold : assert property (@(posedge clock) disable iff (reset)
      !(fire && item_ff.action == ACT_BEGIN) |=> $stable(link_ff.attempt_count))
      else $error("attempt count changed outside a begin event");

   // a bound link always holds a nonzero boot id
   a_bound_boot : assert property (@(posedge clock) disable iff (reset)
      link_ff.link_state == LINK_BOUND |->
         (link_ff.bound_boot_low | link_ff.bound_boot_high) != '0)
      else $error("bound link with zero boot id");

endmodule
